/* src/cpr_pkg.sv */
// Shared types and constants for the clock page replacement block.
`default_nettype none
package cpr_pkg;
  localparam int PageCount   = 64;
  localparam int TotalFrames = 64;
  localparam int RingSlots   = 8;
  localparam int PageW  = $clog2(PageCount);
  localparam int FrameW = $clog2(TotalFrames);
  localparam int SlotW  = $clog2(RingSlots);
  localparam int CountW = $clog2(RingSlots + 1);

  localparam logic [1:0] MODE_XLATE   = 2'd0;
  localparam logic [1:0] MODE_READ    = 2'd1;
  localparam logic [1:0] MODE_WRITE   = 2'd2;
  localparam logic [1:0] MODE_RELEASE = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ABSENT  = 2'd1;
  localparam logic [1:0] ST_NO_FREE = 2'd2;

  localparam logic [0:0] REG_ALGO  = 1'd0;
  localparam logic [0:0] REG_LIMIT = 1'd1;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // capture input word
    logic do_access;  // read/write access, translate hit, or error
    logic do_alloc;   // allocate free frame
    logic do_release; // release all
    logic scan_step;  // examine the slot under the hand
    logic scan_start; // normalize hand
    logic do_evict;   // replace victim at hand
    logic do_nofree;  // fault with no free frame
  } cpr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [1:0] mode;
    logic       present;
    logic       under_limit;
    logic       free_found;
    logic       hit;        // slot under hand is the victim
  } cpr_stat_t;
endpackage
`default_nettype wire

/* src/clock_page_replacement_top.sv */
// Top level of the clock page replacement block.
// Flow: an accepted word is captured, decoded and its result registered for hits, accesses,
//   release and allocation; an eviction first walks the clock hand over the ring slots.
// Throughput: one word at a time; the hand walk that finds the eviction victim moves
//   one slot per cycle.
// Reset: all pages absent, all frames free, ring empty, hand 0, registers default.
`default_nettype none
module clock_page_replacement_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [1:0]                 mode_i,
  input  wire logic [cpr_pkg::PageW-1:0]  page_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [cpr_pkg::FrameW-1:0]      frame_o,
  output logic                            was_fault_o,
  output logic                            evicted_o,
  output logic [cpr_pkg::PageW-1:0]       victim_page_o,
  output logic                            victim_dirty_o,
  output logic [1:0]                      status_o
);
  import cpr_pkg::*;

  logic       algo_q;
  logic [3:0] limit_q;
  logic       res_valid;
  logic       busy;
  cpr_cmd_t   cmd;
  cpr_stat_t  stat;

  assign pready = 1'b1;

  // Register write and read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      algo_q <= 1'b0;
      limit_q <= 4'd4;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_ALGO) algo_q <= pwdata[0];
      else limit_q <= pwdata[3:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_ALGO) prdata = {31'd0, algo_q};
      else prdata = {28'd0, limit_q};
    end
  end

  // Output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (res_valid) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  assign busy = out_valid_o && !out_ready_i;

  cpr_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .out_busy_i(busy), .res_valid_o(res_valid), .stat_i(stat), .cmd_o(cmd)
  );

  cpr_dp u_dp (
    .clk_i, .rst_ni, .mode_i, .page_i, .algo_i(algo_q), .limit_i(limit_q),
    .cmd_i(cmd), .stat_o(stat), .frame_o, .was_fault_o, .evicted_o,
    .victim_page_o, .victim_dirty_o, .status_o
  );
endmodule
`default_nettype wire

/* src/cpr_ctrl.sv */
// Controller state machine for the clock page replacement block.
`default_nettype none
module cpr_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               out_busy_i,
  output logic                    res_valid_o,
  input  wire cpr_pkg::cpr_stat_t stat_i,
  output cpr_pkg::cpr_cmd_t       cmd_o
);
  import cpr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEC  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE) && !out_busy_i;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    res_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (stat_i.mode == MODE_RELEASE) begin
          cmd_o.do_release = 1'b1;
          res_valid_o = 1'b1;
          state_d = S_IDLE;
        end else if (stat_i.mode != MODE_XLATE || stat_i.present) begin
          cmd_o.do_access = 1'b1;
          res_valid_o = 1'b1;
          state_d = S_IDLE;
        end else if (stat_i.under_limit) begin
          cmd_o.do_alloc = stat_i.free_found;
          cmd_o.do_nofree = !stat_i.free_found;
          res_valid_o = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.hit) begin
          cmd_o.do_evict = 1'b1;
          res_valid_o = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

/* src/cpr_dp.sv */
// Datapath for the clock page replacement block: page table, ring, frame map.
`default_nettype none
module cpr_dp (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [1:0]                 mode_i,
  input  wire logic [cpr_pkg::PageW-1:0]  page_i,
  input  wire logic                       algo_i,
  input  wire logic [3:0]                 limit_i,
  input  wire cpr_pkg::cpr_cmd_t          cmd_i,
  output cpr_pkg::cpr_stat_t              stat_o,
  output logic [cpr_pkg::FrameW-1:0]      frame_o,
  output logic                            was_fault_o,
  output logic                            evicted_o,
  output logic [cpr_pkg::PageW-1:0]       victim_page_o,
  output logic                            victim_dirty_o,
  output logic [1:0]                      status_o
);
  import cpr_pkg::*;

  logic [1:0]        mode_q;
  logic [PageW-1:0]  page_q;
  logic [PageCount-1:0]   present_q, used_q, dirty_q;
  logic [FrameW-1:0]      pframe_q [PageCount];
  logic [FrameW-1:0]      pframe_rd_q; // frame of the captured page, read at load
  logic [TotalFrames-1:0] busy_q;
  logic [PageW-1:0]  rpage_q  [RingSlots];
  logic [FrameW-1:0] rframe_q [RingSlots];
  logic [CountW-1:0] count_q;
  logic [SlotW-1:0]  hand_q;
  logic              pass2_q;   // enhanced clock: in the use-clearing pass
  logic [CountW-1:0] steps_q;   // slots looked at in this pass
  logic [SlotW-1:0]  next_hand;
  logic [PageW-1:0]  hpage;
  logic [FrameW-1:0] free_f;
  logic              free_ok;
  logic [CountW-1:0] lim;

  // Effective frame limit, clamped to 1..RingSlots
  always_comb begin
    if (limit_i == 4'd0) lim = CountW'(1);
    else if (32'(limit_i) > RingSlots) lim = CountW'(RingSlots);
    else lim = CountW'(limit_i);
  end

  // Lowest free frame
  always_comb begin
    free_f = '0;
    free_ok = 1'b0;
    for (int i = TotalFrames - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_f = FrameW'(i);
        free_ok = 1'b1;
      end
    end
  end

  assign hpage = rpage_q[hand_q];
  assign next_hand = (CountW'(hand_q) + CountW'(1) < count_q) ? hand_q + SlotW'(1) : '0;

  always_comb begin
    stat_o.mode = mode_q;
    stat_o.present = present_q[page_q];
    stat_o.under_limit = count_q < lim;
    stat_o.free_found = free_ok;
    if (!algo_i) stat_o.hit = !used_q[hpage];
    else stat_o.hit = !used_q[hpage] && (dirty_q[hpage] == pass2_q);
  end

  // Input capture and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      page_q <= page_i;
      pframe_rd_q <= pframe_q[page_i];
    end
    if (cmd_i.do_access || cmd_i.do_release || cmd_i.do_alloc || cmd_i.do_nofree
        || cmd_i.do_evict) begin
      frame_o <= '0;
      was_fault_o <= 1'b0;
      evicted_o <= 1'b0;
      victim_page_o <= '0;
      victim_dirty_o <= 1'b0;
      status_o <= ST_OK;
      if (cmd_i.do_access) begin
        if (present_q[page_q]) frame_o <= pframe_rd_q;
        else status_o <= ST_ABSENT;
      end
      if (cmd_i.do_nofree) begin
        was_fault_o <= 1'b1;
        status_o <= ST_NO_FREE;
      end
      if (cmd_i.do_alloc) begin
        was_fault_o <= 1'b1;
        frame_o <= free_f;
      end
      if (cmd_i.do_evict) begin
        was_fault_o <= 1'b1;
        evicted_o <= 1'b1;
        victim_page_o <= hpage;
        victim_dirty_o <= dirty_q[hpage];
        frame_o <= rframe_q[hand_q];
      end
    end
    // Page frame and ring entries
    if (cmd_i.do_alloc) begin
      pframe_q[page_q] <= free_f;
      rpage_q[count_q[SlotW-1:0]] <= page_q;
      rframe_q[count_q[SlotW-1:0]] <= free_f;
    end
    if (cmd_i.do_evict) begin
      pframe_q[page_q] <= rframe_q[hand_q];
      rpage_q[hand_q] <= page_q;
    end
  end

  // Control state: page bits, frame map, ring count, hand
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      used_q <= '0;
      dirty_q <= '0;
      busy_q <= '0;
      count_q <= '0;
      hand_q <= '0;
      pass2_q <= 1'b0;
      steps_q <= '0;
    end else begin
      if (cmd_i.do_release) begin
        // Every busy frame belongs to a present page of this one process
        busy_q <= '0;
        present_q <= '0;
        used_q <= '0;
        dirty_q <= '0;
        count_q <= '0;
        hand_q <= '0;
      end
      if (cmd_i.do_access && present_q[page_q] && mode_q != MODE_XLATE) begin
        used_q[page_q] <= 1'b1;
        if (mode_q == MODE_WRITE) dirty_q[page_q] <= 1'b1;
      end
      if (cmd_i.do_alloc) begin
        busy_q[free_f] <= 1'b1;
        present_q[page_q] <= 1'b1;
        used_q[page_q] <= 1'b1;
        dirty_q[page_q] <= 1'b0;
        count_q <= count_q + CountW'(1);
      end
      if (cmd_i.scan_start) begin
        pass2_q <= 1'b0;
        steps_q <= '0;
        if (CountW'(hand_q) >= count_q) hand_q <= '0;
      end
      if (cmd_i.scan_step) begin
        if (!algo_i || pass2_q) used_q[hpage] <= 1'b0;
        hand_q <= next_hand;
        if (steps_q + CountW'(1) >= count_q) begin
          steps_q <= '0;
          pass2_q <= !pass2_q;
        end else begin
          steps_q <= steps_q + CountW'(1);
        end
      end
      if (cmd_i.do_evict) begin
        present_q[hpage] <= 1'b0;
        used_q[hpage] <= 1'b0;
        dirty_q[hpage] <= 1'b0;
        present_q[page_q] <= 1'b1;
        used_q[page_q] <= 1'b1;
        dirty_q[page_q] <= 1'b0;
        hand_q <= next_hand;
      end
    end
  end
endmodule
`default_nettype wire

/* src/cpr_checker.sv */
// Port-level checker for the clock page replacement block, with its bind.
`default_nettype none
module cpr_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [1:0] mode_i,
  input wire logic       was_fault_o,
  input wire logic       evicted_o,
  input wire logic [1:0] status_o
);
  import cpr_pkg::*;

  a_no_accept_while_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o) else $error("accept while held");
  a_evict_is_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && evicted_o) |-> (was_fault_o && status_o == ST_OK))
    else $error("evict without fault");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_NO_FREE) else $error("bad status");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(status_o)))
    else $error("output changed while held");
  a_release_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && mode_i == MODE_RELEASE) |=> ##1 out_valid_o)
    else $error("release result late");
endmodule

bind clock_page_replacement_top cpr_checker u_cpr_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .mode_i, .was_fault_o, .evicted_o, .status_o
);
`default_nettype wire
